// ===== rtl/lzw_pkg.sv =====
// Shared constants and control types for the LZW byte stream encoder.
package lzw_pkg;

  localparam int BYTE_W          = 8;
  localparam int START_CODE_BITS = 9;
  localparam int FIRST_CODE      = 256;
  localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

  // Code request from the sequencer to the bit packer
  typedef struct packed {
    logic push;        // code request this cycle
    logic final_code;  // last code of the stream, flush the tail afterwards
  } pk_ctl_t;

endpackage

// ===== rtl/lzw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lzw_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/lzw_pack.sv =====
// LSB-first bit packer: takes variable-width codes, gives a byte per ready cycle.
module lzw_pack #(
  parameter int MAX_CODE_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lzw_pkg::pk_ctl_t                     ctl,
  input  logic [MAX_CODE_BITS-1:0]             code,
  input  logic [$clog2(MAX_CODE_BITS+1)-1:0]   width,
  output logic                                 ready,
  output logic [lzw_pkg::BYTE_W-1:0]           out_byte,
  output logic                                 out_last,
  output logic                                 out_valid,
  input  logic                                 out_ready
);
  import lzw_pkg::*;

  localparam int BW = MAX_CODE_BITS + BYTE_W - 1;   // widest bit buffer
  localparam int CW = $clog2(BW + 1);                // bit count width
  localparam int WW = $clog2(MAX_CODE_BITS + 1);
  localparam logic [CW-1:0] BYTE_CNT = CW'(BYTE_W);

  typedef enum logic {P_IDLE, P_DRAIN} pk_state_t;

  pk_state_t      state;
  logic [BW-1:0]  bits;
  logic [CW-1:0]  count;
  logic           final_flag;
  logic           have_byte;
  logic           out_free;
  logic           load_byte;
  logic [BW-1:0]  code_shift;

  // a byte is due when 8 bits are held, or on flush when any bit is left
  assign have_byte  = (count >= BYTE_CNT) || (final_flag && (count != '0));
  assign out_free   = !out_valid || out_ready;
  assign load_byte  = (state == P_DRAIN) && have_byte && out_free;
  assign code_shift = {{(BW-MAX_CODE_BITS){1'b0}}, code} << count[2:0];
  assign ready      = (state == P_IDLE);

  // packer state, bit buffer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= P_IDLE;
      bits       <= '0;
      count      <= '0;
      final_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load_byte) begin
        out_valid <= 1'b0;
      end
      case (state)
        P_IDLE: begin
          if (ctl.push) begin
            bits       <= bits | code_shift;
            count      <= count + CW'({{(CW-WW){1'b0}}, width});
            final_flag <= ctl.final_code;
            state      <= P_DRAIN;
          end
        end
        P_DRAIN: begin
          if (have_byte) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_byte  <= bits[BYTE_W-1:0] & BYTE_MASK;
              out_last  <= final_flag && (count <= BYTE_CNT);
              bits      <= bits >> BYTE_W;
              count     <= (count >= BYTE_CNT) ? (count - BYTE_CNT) : '0;
            end
          end else begin
            state <= P_IDLE;
            if (final_flag) begin
              bits       <= '0;
              count      <= '0;
              final_flag <= 1'b0;
            end
          end
        end
        default: state <= P_IDLE;
      endcase
    end
  end

  // fewer than 8 bits remain whenever a new code may come in
  a_idle_partial: assert property (@(posedge clk) disable iff (rst)
    (state == P_IDLE) |-> (count < BYTE_CNT))
    else $error("packer idle with a full byte pending");

  // requests arrive only when the packer is ready
  a_push_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> (state == P_IDLE))
    else $error("code request while packer busy");

  // a finished flush leaves no stray bits above the count
  a_flush_clean: assert property (@(posedge clk) disable iff (rst)
    (state == P_DRAIN && !have_byte && final_flag) |-> (bits == '0))
    else $error("bits left above count after flush");

endmodule

// ===== rtl/lzw_byte_stream_encoder_unit.sv =====
// Top level: LZW encoder sequencer with a linear dictionary search unit.
// Sequencing: the first byte of a stream only starts the prefix; each later byte is
//   searched from code 256 up to free_code; a miss is emitted once the packer is free.
// Throughput: one byte per search; a last byte adds a final emit that waits for the packer
//   to drain the previous code. Bytes leave one per cycle in drain while out_ready is high.
// Reset: clears control state to an empty stream; the dictionary is not cleared.
module lzw_byte_stream_encoder_unit #(
  parameter int MAX_CODE_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [lzw_pkg::BYTE_W-1:0] data_byte,
  input  logic                       last_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [lzw_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last
);
  import lzw_pkg::*;

  localparam int DEPTH = 1 << MAX_CODE_BITS;
  localparam int FW    = MAX_CODE_BITS + 1;            // free code / scan index
  localparam int WW    = $clog2(MAX_CODE_BITS + 1);    // code width register
  localparam int KW    = MAX_CODE_BITS + BYTE_W;       // dictionary entry
  localparam logic [FW-1:0] FIRST_C = FW'(FIRST_CODE);
  localparam logic [FW-1:0] DEPTH_C = FW'(DEPTH);
  localparam logic [WW-1:0] START_W = WW'(START_CODE_BITS);
  localparam logic [WW-1:0] MAX_W   = WW'(MAX_CODE_BITS);
  localparam logic [FW-1:0] ONE_F   = FW'(1);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_EMIT, S_FINAL} state_t;

  state_t                    state;
  logic [MAX_CODE_BITS-1:0]  prefix_code;
  logic                      prefix_valid;
  logic [FW-1:0]             free_code;
  logic [WW-1:0]             code_width;
  logic [BYTE_W-1:0]         byte_reg;
  logic                      last_reg;
  logic [FW-1:0]             search_idx;
  logic                      cmp_valid;
  logic [MAX_CODE_BITS-1:0]  cmp_code;

  logic [KW-1:0]             rd_data;
  logic [KW-1:0]             key;
  logic                      hit;
  logic                      dict_full;
  logic                      dict_we;
  logic [FW-1:0]             free_code_next;
  pk_ctl_t                   pk_ctl;
  logic                      pk_ready;

  // search key and compare unit
  assign key       = {prefix_code, byte_reg};
  assign hit       = cmp_valid && (rd_data == key);
  assign dict_full = free_code[MAX_CODE_BITS];
  assign dict_we   = (state == S_EMIT) && pk_ready && !dict_full;
  assign free_code_next = free_code + ONE_F;
  assign in_ready  = (state == S_IDLE);

  // code requests to the packer
  always_comb begin
    pk_ctl.push       = ((state == S_EMIT) || (state == S_FINAL)) && pk_ready;
    pk_ctl.final_code = (state == S_FINAL);
  end

  lzw_ram #(
    .WIDTH (KW),
    .DEPTH (DEPTH)
  ) u_dict (
    .clk     (clk),
    .we      (dict_we),
    .wr_addr (free_code[MAX_CODE_BITS-1:0]),
    .wr_data (key),
    .rd_addr (search_idx[MAX_CODE_BITS-1:0]),
    .rd_data (rd_data)
  );

  lzw_pack #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_pack (
    .clk       (clk),
    .rst       (rst),
    .ctl       (pk_ctl),
    .code      (prefix_code),
    .width     (code_width),
    .ready     (pk_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // sequencer: accept, scan dictionary, emit, flush
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prefix_code  <= '0;
      prefix_valid <= 1'b0;
      free_code    <= FIRST_C;
      code_width   <= START_W;
      cmp_valid    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            byte_reg   <= data_byte;
            last_reg   <= last_byte;
            search_idx <= FIRST_C;
            cmp_valid  <= 1'b0;
            if (!prefix_valid) begin
              // first byte of a stream only starts the prefix
              prefix_code  <= MAX_CODE_BITS'(data_byte);
              prefix_valid <= 1'b1;
              state        <= last_byte ? S_FINAL : S_IDLE;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (hit) begin
            prefix_code <= cmp_code;
            cmp_valid   <= 1'b0;
            state       <= last_reg ? S_FINAL : S_IDLE;
          end else if (search_idx == free_code) begin
            cmp_valid <= 1'b0;
            state     <= S_EMIT;
          end else begin
            cmp_valid  <= 1'b1;
            cmp_code   <= search_idx[MAX_CODE_BITS-1:0];
            search_idx <= search_idx + ONE_F;
          end
        end
        S_EMIT: begin
          // emit prefix at the old width, then add the new entry
          if (pk_ready) begin
            if (!dict_full) begin
              free_code <= free_code_next;
              if ((code_width < MAX_W) && (free_code_next > (ONE_F << code_width))) begin
                code_width <= code_width + WW'(1);
              end
            end
            prefix_code <= MAX_CODE_BITS'(byte_reg);
            state       <= last_reg ? S_FINAL : S_IDLE;
          end
        end
        S_FINAL: begin
          // final code goes out, stream state returns to reset values
          if (pk_ready) begin
            prefix_code  <= '0;
            prefix_valid <= 1'b0;
            free_code    <= FIRST_C;
            code_width   <= START_W;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    (code_width >= START_W) && (code_width <= MAX_W))
    else $error("code width out of range");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    (free_code >= FIRST_C) && (free_code <= DEPTH_C))
    else $error("free code out of range");

  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    (pk_ctl.push && pk_ctl.final_code) |=>
      (!prefix_valid && (free_code == FIRST_C) && (code_width == START_W)))
    else $error("stream state not reset after final code");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (search_idx <= free_code))
    else $error("dictionary scan ran past free code");

endmodule
